@@ sv/lav_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg: shared types for the look-at view matrix block
// Sequencer states, vector pass codes and the arithmetic unit request.
// ----------------------------------------------------------------------------
package lav_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_SQ,
    S_SQRT,
    S_DIV,
    S_CROSS,
    S_OUT
  } state_t;

  // which vector the normalize sequence is working on
  typedef enum logic [1:0] {
    PASS_Z,
    PASS_X,
    PASS_Y
  } pass_t;

  typedef enum logic [1:0] {
    AR_MUL,
    AR_SQRT,
    AR_DIV
  } ar_op_t;

  typedef struct packed {
    logic   start;
    ar_op_t op;
  } ar_req_t;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

endpackage

@@ sv/lav_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_if: input and output channels of the look-at view matrix block
// Valid/ready channels carrying the camera item and the rotation item.
// ----------------------------------------------------------------------------
interface lav_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] eye_x;
  logic [31:0] eye_y;
  logic [31:0] eye_z;
  logic [31:0] target_x;
  logic [31:0] target_y;
  logic [31:0] target_z;
  logic [31:0] up_x;
  logic [31:0] up_y;
  logic [31:0] up_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                up_x, up_y, up_z, output ready);
endinterface

interface lav_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] right_x;
  logic [31:0] right_y;
  logic [31:0] right_z;
  logic [31:0] upv_x;
  logic [31:0] upv_y;
  logic [31:0] upv_z;
  logic [31:0] back_x;
  logic [31:0] back_y;
  logic [31:0] back_z;
  logic        degenerate;

  modport source (output valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
                  back_x, back_y, back_z, degenerate, input ready);
  modport sink (input valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
                back_x, back_y, back_z, degenerate, output ready);
endinterface

@@ sv/lav_arith.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_arith: shared bit-serial arithmetic unit
// Unsigned 32x32 multiply, 64-bit integer square root and 64/32 division,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module lav_arith
  import lav_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ar_req_t     req,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] result
);

  logic        busy;
  ar_op_t      op;
  logic [4:0]  cnt;
  logic [63:0] x;
  logic [31:0] y;
  logic [63:0] acc;
  logic [34:0] rem;
  logic [31:0] quo;

  logic [63:0] acc_next;
  logic [34:0] rem_next;
  logic [31:0] quo_next;
  logic [63:0] x_next;
  logic [34:0] r4;
  logic [34:0] trial;
  logic [34:0] r2;

  // one step of the selected operation
  always_comb begin
    acc_next = acc;
    rem_next = rem;
    quo_next = quo;
    x_next   = x;
    r4       = {rem[32:0], x[63:62]};
    trial    = {1'b0, quo, 2'b01};
    r2       = {rem[33:0], x[63]};
    case (op)
      AR_MUL: begin
        acc_next = {acc[62:0], 1'b0} + (x[63] ? {32'b0, y} : 64'b0);
        x_next   = {x[62:0], 1'b0};
      end
      AR_SQRT: begin
        if (r4 >= trial) begin
          rem_next = r4 - trial;
          quo_next = {quo[30:0], 1'b1};
        end else begin
          rem_next = r4;
          quo_next = {quo[30:0], 1'b0};
        end
        x_next = {x[61:0], 2'b00};
      end
      AR_DIV: begin
        if (r2 >= {3'b0, y}) begin
          rem_next = r2 - {3'b0, y};
          quo_next = {quo[30:0], 1'b1};
        end else begin
          rem_next = r2;
          quo_next = {quo[30:0], 1'b0};
        end
        x_next = {x[62:0], 1'b0};
      end
      default: begin
        x_next = x;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      y   <= b;
      acc <= '0;
      quo <= '0;
      if (req.op == AR_SQRT) begin
        x   <= a;
        rem <= '0;
      end else begin
        x   <= {a[31:0], 32'b0};
        rem <= {3'b0, a[63:32]};
      end
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
      quo <= quo_next;
      x   <= x_next;
    end
  end

  assign result = (op == AR_MUL) ? acc : {32'b0, quo};

endmodule

@@ sv/look_at_view_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix: look-at view rotation in fixed point
// Builds the normalized back, right and up rows of a look-at view matrix
// from eye, target and up vectors; repeats the last matrix if eye = target.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  cam      in   valid / ready  eye, target, up (Q16.16, 3 x 3 x 32)
//  view     out  valid / ready  right, upv, back (Q1.30, 9 x 32), degenerate
//
//  One item at a time. A normal item takes twelve cross-product multiplies,
//  nine squares, three square roots and nine divisions in the shared
//  bit-serial unit, plus one-bit normalize shifts per vector. When the right
//  vector comes out zero, its pass and the up pass skip the square, root and
//  divide steps.
//  Reset clears the stored matrix to zero. A stalled view holds its item;
//  the next cam item is taken while it waits.
// ----------------------------------------------------------------------------
module look_at_view_matrix
  import lav_pkg::*;
(
  input logic clk,
  input logic rst,
  lav_in_if.sink    cam,
  lav_out_if.source view
);

  localparam logic [1:0] CA_IDX [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] CB_IDX [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

  state_t state, state_next;
  pass_t  pass;
  logic   pend;
  logic [2:0] idx;

  logic signed [31:0] up [3];
  logic [63:0]        mag [3];
  logic               neg [3];
  logic [63:0]        acc;
  logic [31:0]        len;
  logic signed [31:0] zn [3];
  logic signed [31:0] xn [3];
  logic signed [31:0] yn [3];
  logic signed [31:0] last [9];
  logic               deg;

  logic               ovalid;
  logic [31:0]        omat [9];
  logic               odeg;

  ar_req_t     ar_req;
  logic [63:0] ar_a;
  logic [31:0] ar_b;
  logic        ar_done;
  logic [63:0] ar_res;

  logic signed [31:0] in_eye [3];
  logic signed [31:0] in_tgt [3];
  logic signed [32:0] d [3];
  logic               same;
  logic [63:0]        orv;
  logic               shift_r;
  logic               shift_l;
  logic signed [31:0] ca;
  logic signed [31:0] cb;
  logic [31:0]        ca_mag;
  logic [31:0]        cb_mag;
  logic signed [63:0] prod_s;
  logic signed [63:0] diff;
  logic [31:0]        qc;
  logic signed [31:0] qs;
  logic               step_done;
  state_t             after_pass;

  lav_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (ar_req),
    .a      (ar_a),
    .b      (ar_b),
    .done   (ar_done),
    .result (ar_res)
  );

  // gather the input item and form eye - target
  always_comb begin
    in_eye[0] = cam.eye_x;
    in_eye[1] = cam.eye_y;
    in_eye[2] = cam.eye_z;
    in_tgt[0] = cam.target_x;
    in_tgt[1] = cam.target_y;
    in_tgt[2] = cam.target_z;
    for (int i = 0; i < 3; i++) begin
      d[i] = {in_eye[i][31], in_eye[i]} - {in_tgt[i][31], in_tgt[i]};
    end
    same = (cam.eye_x == cam.target_x) && (cam.eye_y == cam.target_y) &&
           (cam.eye_z == cam.target_z);
  end

  // normalize shift decision, cross operands, quotient rounding
  always_comb begin
    orv     = mag[0] | mag[1] | mag[2];
    shift_r = |orv[63:31];
    shift_l = !orv[30];
    ca      = (pass == PASS_X) ? up[CA_IDX[idx]] : zn[CA_IDX[idx]];
    cb      = (pass == PASS_X) ? zn[CB_IDX[idx]] : xn[CB_IDX[idx]];
    ca_mag  = ca[31] ? 32'(-ca) : 32'(ca);
    cb_mag  = cb[31] ? 32'(-cb) : 32'(cb);
    prod_s  = (ca[31] ^ cb[31]) ? -$signed(ar_res) : $signed(ar_res);
    diff    = $signed(acc) - prod_s;
    qc      = (ar_res[31:0] > ONE_Q30) ? ONE_Q30 : ar_res[31:0];
    qs      = neg[idx[1:0]] ? -$signed(qc) : $signed(qc);
    step_done = pend && ar_done;
    case (pass)
      PASS_Z:  after_pass = S_CROSS;
      PASS_X:  after_pass = S_CROSS;
      default: after_pass = S_OUT;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cam.valid) begin
          state_next = same ? S_OUT : S_NORM;
        end
      end
      S_NORM: begin
        if (orv == 64'b0) begin
          state_next = after_pass;
        end else if (!shift_r && !shift_l) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        if (step_done && idx == 3'd2) begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (step_done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step_done && idx == 3'd2) begin
          state_next = after_pass;
        end
      end
      S_CROSS: begin
        if (step_done && idx == 3'd5) begin
          state_next = S_NORM;
        end
      end
      S_OUT: begin
        if (!ovalid || view.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs: arithmetic requests and input ready
  always_comb begin
    ar_req.start = 1'b0;
    ar_req.op    = AR_MUL;
    ar_a         = {32'b0, mag[idx[1:0]][31:0]};
    ar_b         = mag[idx[1:0]][31:0];
    case (state)
      S_SQ: begin
        ar_req.start = !pend;
      end
      S_SQRT: begin
        ar_req.start = !pend;
        ar_req.op    = AR_SQRT;
        ar_a         = acc;
      end
      S_DIV: begin
        ar_req.start = !pend;
        ar_req.op    = AR_DIV;
        ar_a         = {mag[idx[1:0]][33:0], 30'b0} + {33'b0, len[31:1]};
        ar_b         = len;
      end
      S_CROSS: begin
        ar_req.start = !pend;
        ar_a         = {32'b0, ca_mag};
        ar_b         = cb_mag;
      end
      default: begin
        ar_req.start = 1'b0;
      end
    endcase
  end

  assign cam.ready = (state == S_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend   <= 1'b0;
      ovalid <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        last[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (ar_req.start) begin
        pend <= 1'b1;
      end else if (ar_done) begin
        pend <= 1'b0;
      end
      if (state == S_OUT && (!ovalid || view.ready)) begin
        ovalid <= 1'b1;
        if (!deg) begin
          for (int i = 0; i < 3; i++) begin
            last[i]     <= xn[i];
            last[3 + i] <= yn[i];
            last[6 + i] <= zn[i];
          end
        end
      end else if (view.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cam.valid) begin
          deg     <= same;
          pass    <= PASS_Z;
          up[0]   <= cam.up_x;
          up[1]   <= cam.up_y;
          up[2]   <= cam.up_z;
          for (int i = 0; i < 3; i++) begin
            neg[i] <= d[i][32];
            mag[i] <= {31'b0, d[i][32] ? 33'(-d[i]) : 33'(d[i])};
          end
        end
      end
      S_NORM: begin
        if (orv == 64'b0) begin
          for (int i = 0; i < 3; i++) begin
            case (pass)
              PASS_Z:  zn[i] <= '0;
              PASS_X:  xn[i] <= '0;
              default: yn[i] <= '0;
            endcase
          end
          idx <= '0;
          if (pass == PASS_Z) begin
            pass <= PASS_X;
          end else if (pass == PASS_X) begin
            pass <= PASS_Y;
          end
        end else if (shift_r) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= {1'b0, mag[i][63:1]};
          end
        end else if (shift_l) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= {mag[i][62:0], 1'b0};
          end
        end else begin
          idx <= '0;
          acc <= '0;
        end
      end
      S_SQ: begin
        if (step_done) begin
          acc <= acc + ar_res;
          idx <= idx + 3'd1;
        end
      end
      S_SQRT: begin
        if (step_done) begin
          len <= ar_res[31:0];
          idx <= '0;
        end
      end
      S_DIV: begin
        if (step_done) begin
          case (pass)
            PASS_Z:  zn[idx[1:0]] <= qs;
            PASS_X:  xn[idx[1:0]] <= qs;
            default: yn[idx[1:0]] <= qs;
          endcase
          if (idx == 3'd2) begin
            idx <= '0;
            if (pass == PASS_Z) begin
              pass <= PASS_X;
            end else if (pass == PASS_X) begin
              pass <= PASS_Y;
            end
          end else begin
            idx <= idx + 3'd1;
          end
        end
      end
      S_CROSS: begin
        if (step_done) begin
          if (!idx[0]) begin
            acc <= prod_s;
          end else begin
            neg[idx[2:1]] <= diff[63];
            mag[idx[2:1]] <= diff[63] ? 64'(-diff) : 64'(diff);
          end
          idx <= (idx == 3'd5) ? 3'd0 : idx + 3'd1;
        end
      end
      S_OUT: begin
        if (!ovalid || view.ready) begin
          odeg <= deg;
          if (deg) begin
            for (int i = 0; i < 9; i++) begin
              omat[i] <= last[i];
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              omat[i]     <= xn[i];
              omat[3 + i] <= yn[i];
              omat[6 + i] <= zn[i];
            end
          end
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // drive the output channel
  assign view.valid      = ovalid;
  assign view.right_x    = omat[0];
  assign view.right_y    = omat[1];
  assign view.right_z    = omat[2];
  assign view.upv_x      = omat[3];
  assign view.upv_y      = omat[4];
  assign view.upv_z      = omat[5];
  assign view.back_x     = omat[6];
  assign view.back_y     = omat[7];
  assign view.back_z     = omat[8];
  assign view.degenerate = odeg;

  // a unit result arrives only for a request still outstanding
  a_done_pend: assert property (@(posedge clk) disable iff (rst) ar_done |-> pend)
    else $error("arithmetic result without outstanding request");

  // a new request never overlaps one in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    ar_req.start |-> !pend)
    else $error("arithmetic request issued while busy");

  // the first component of the back row never exceeds one in magnitude
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !deg) |->
      ($signed(zn[0]) <= $signed(ONE_Q30) && $signed(zn[0]) >= -$signed(ONE_Q30)))
    else $error("normalized component out of range");

endmodule
